// ===== src/irat_pkg.sv =====
// Shared types and constants for the interleaved region address translator.
// Holds the table entry record, the mapping request record and the status/kind codes.
// No dependencies.
`default_nettype none

package irat_pkg;

	localparam int VA_W    = 64;
	localparam int LEN_W   = 41;
	localparam int PHYS_W  = 37;
	localparam int BLK_W   = 6;
	localparam int NODES_W = 4;
	localparam int START_W = 10;
	localparam int MPN_W   = 38;
	localparam int STAT_W  = 2;

	// input tdata layout, lowest bit first
	localparam int OFS_VIRT   = 0;
	localparam int OFS_BYTES  = OFS_VIRT + VA_W;
	localparam int OFS_PHYS   = OFS_BYTES + LEN_W;
	localparam int OFS_BLK    = OFS_PHYS + PHYS_W;
	localparam int OFS_NODES  = OFS_BLK + BLK_W;
	localparam int OFS_FIRST  = OFS_NODES + NODES_W;
	localparam int IN_FIELDS_W = OFS_FIRST + START_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	localparam logic KIND_INSTALL   = 1'b0;
	localparam logic KIND_TRANSLATE = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

	// register select: registers sit at byte addresses 0 and 8
	localparam int          CFG_ADDR_W     = 4;
	localparam int          CFG_SEL_BIT    = 3;
	localparam logic        CFG_SEL_WINDOW = 1'b0;
	localparam logic        CFG_SEL_MPN    = 1'b1;

	typedef struct packed {
		logic [VA_W-1:0]    va_base;
		logic [LEN_W-1:0]   length;
		logic [PHYS_W-1:0]  phys_low;
		logic [BLK_W-1:0]   block_log2;
		logic [NODES_W-1:0] nodes_log2;
		logic [START_W-1:0] start_node;
	} entry_t;

	typedef struct packed {
		logic [VA_W-1:0]    virt;
		logic [LEN_W-1:0]   off;
		logic [PHYS_W-1:0]  phys_low;
		logic [BLK_W-1:0]   block_log2;
		logic [NODES_W-1:0] nodes_log2;
		logic [START_W-1:0] start_node;
	} map_req_t;

endpackage

`default_nettype wire

// ===== src/irat_map.sv =====
// Address mapping pipeline: turns a matched region offset into the interleaved address.
// Five registered stages; depends on irat_pkg.
`default_nettype none

module irat_map
	import irat_pkg::*;
#(
	parameter int NODE_LOG2 = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire map_req_t         req,
	input  wire logic [VA_W-1:0]  window_base,
	input  wire logic [MPN_W-1:0] mem_per_node,
	output logic                  done,
	output logic [VA_W-1:0]       phys_addr
);

	localparam int SUM_W  = ((NODE_LOG2 > START_W) ? NODE_LOG2 : START_W) + 1;
	localparam int LOW_W  = LEN_W + 1;
	localparam int LOW2_W = LOW_W + 1;
	localparam int PROD_W = MPN_W + SUM_W;
	localparam int ACC_W  = ((PROD_W > LOW2_W) ? PROD_W : LOW2_W) + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	map_req_t           req_s1;
	logic [SUM_W-1:0]   nsum_s2;
	logic [LOW_W-1:0]   low_s2;
	logic               single_s2, single_s3, single_s4;
	logic [VA_W-1:0]    virt_s2, virt_s3, virt_s4;
	logic [PHYS_W-1:0]  phys_s2;
	logic [PROD_W-1:0]  prod_s3;
	logic [LOW2_W-1:0]  low2_s3;
	logic [ACC_W-1:0]   acc_s4;
	logic [VA_W-1:0]    res_s5;

	logic [6:0]           wsum;
	logic [6:0]           wid;
	logic                 wid_pos;
	logic [LEN_W-1:0]     blk;
	logic [LEN_W-1:0]     node_full;
	logic [LEN_W-1:0]     in_node;
	logic [LEN_W-1:0]     boff;
	logic [LOW_W-1:0]     in_node_sh;
	logic [NODE_LOG2-1:0] node;

	// split the offset into block offset, node and block-in-node
	always_comb begin
		wsum       = 7'(PHYS_W) + 7'(req_s1.nodes_log2);
		wid_pos    = wsum > 7'(req_s1.block_log2);
		wid        = wsum - 7'(req_s1.block_log2);
		blk        = wid_pos ? ((req_s1.off >> req_s1.block_log2) & ~({LEN_W{1'b1}} << wid))
		                     : '0;
		node_full  = blk & ~({LEN_W{1'b1}} << req_s1.nodes_log2);
		node       = node_full[NODE_LOG2-1:0];
		in_node    = blk >> req_s1.nodes_log2;
		in_node_sh = LOW_W'(in_node) << req_s1.block_log2;
		boff       = req_s1.off & ~({LEN_W{1'b1}} << req_s1.block_log2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
		nsum_s2   <= SUM_W'(node) + SUM_W'(req_s1.start_node);
		low_s2    <= in_node_sh + LOW_W'(boff);
		single_s2 <= (req_s1.nodes_log2 == '0);
		virt_s2   <= req_s1.virt;
		phys_s2   <= req_s1.phys_low;

		prod_s3   <= PROD_W'(mem_per_node) * PROD_W'(nsum_s2);
		low2_s3   <= LOW2_W'(low_s2) + LOW2_W'(phys_s2);
		single_s3 <= single_s2;
		virt_s3   <= virt_s2;

		acc_s4    <= ACC_W'(prod_s3) + ACC_W'(low2_s3);
		single_s4 <= single_s3;
		virt_s4   <= virt_s3;

		res_s5    <= single_s4 ? virt_s4 : (window_base + VA_W'(acc_s4));
	end

	assign done      = v_s5;
	assign phys_addr = res_s5;

endmodule

`default_nettype wire

// ===== src/interleaved_region_address_translate.sv =====
// An install moves from accept to the response state; a translate scans the used entries
// in order and on the first match runs the mapping pipeline, else ends after the last one.
// Throughput: one item at a time; the next item is taken the cycle after the result loads
// the output register, which waits while a previous result is stalled on the output.
// The region table is one synchronous memory read one entry per cycle; that scan sets the rate.
// Reset (arst_n, async, active low) clears state, fill count, output valid and registers.
`default_nettype none

module interleaved_region_address_translate
	import irat_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int MAX_NODES     = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// input items
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: virt_addr[63:0], region_bytes[104:64], region_phys[141:105],
	//        block_log2[147:142], nodes_log2[151:148], first_node[161:152], zero pad
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	// tuser: kind[0]
	input  wire logic [0:0]            s_axis_tuser,

	// result items
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tdata: phys_addr[63:0]
	output logic [VA_W-1:0]            m_axis_tdata,
	// tuser: status[1:0]
	output logic [STAT_W-1:0]          m_axis_tuser,

	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [63:0]           pwdata,
	output logic [63:0]                prdata,
	output logic                       pready
);

	localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
	localparam int NODE_LOG2 = $clog2(MAX_NODES + 1) - 1;
	localparam logic [NODES_W-1:0] NODES_MAX = NODES_W'(NODE_LOG2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_MAP  = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	// ---------------------------------------------------------------- config
	logic [VA_W-1:0]  window_q;
	logic [MPN_W-1:0] mpn_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			mpn_q    <= '0;
		end else if (cfg_wr) begin
			if (paddr[CFG_SEL_BIT] == CFG_SEL_MPN) begin
				mpn_q <= pwdata[MPN_W-1:0];
			end else begin
				window_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[CFG_SEL_BIT] == CFG_SEL_MPN) ? 64'(mpn_q) : window_q;

	// ---------------------------------------------------------------- input
	logic             in_acc;
	logic             in_kind;
	logic [NODES_W-1:0] in_nodes;
	entry_t           new_entry;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_kind  = s_axis_tuser[0];
	assign in_nodes = s_axis_tdata[OFS_NODES +: NODES_W];

	// clamp the node count so 2^nodes_log2 never exceeds MAX_NODES
	always_comb begin
		new_entry.va_base    = s_axis_tdata[OFS_VIRT +: VA_W];
		new_entry.length     = s_axis_tdata[OFS_BYTES +: LEN_W];
		new_entry.phys_low   = s_axis_tdata[OFS_PHYS +: PHYS_W];
		new_entry.block_log2 = s_axis_tdata[OFS_BLK +: BLK_W];
		new_entry.nodes_log2 = (in_nodes > NODES_MAX) ? NODES_MAX : in_nodes;
		new_entry.start_node = s_axis_tdata[OFS_FIRST +: START_W];
	end

	// ---------------------------------------------------------------- control
	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [VA_W-1:0]    virt_q;
	logic               rd_valid_s1;
	entry_t             rd_data_s1;
	entry_t             entries_q [TABLE_ENTRIES];

	logic               full;
	logic               wr_en;
	logic               issue;
	logic [VA_W:0]      diff;
	logic               hit;
	map_req_t           map_req;
	logic               map_done;
	logic [VA_W-1:0]    map_addr;

	logic [VA_W-1:0]    res_data_q;
	logic [STAT_W-1:0]  res_status_q;
	logic               m_valid_q;
	logic [VA_W-1:0]    m_data_q;
	logic [STAT_W-1:0]  m_user_q;
	logic               out_load;

	assign full  = (count_q == CNT_W'(TABLE_ENTRIES));
	assign wr_en = in_acc && (in_kind == KIND_INSTALL) && !full;
	// entries fill in order, so any index below the count is a valid entry
	assign issue = (state_q == ST_SCAN) && (idx_q < count_q);

	// range test: virt >= base and virt - base < length, no wrap of base + length
	assign diff = {1'b0, virt_q} - {1'b0, rd_data_s1.va_base};
	assign hit  = (state_q == ST_SCAN) && rd_valid_s1 && !diff[VA_W]
	              && (diff[VA_W-1:0] < VA_W'(rd_data_s1.length));

	always_comb begin
		map_req.virt       = virt_q;
		map_req.off        = diff[LEN_W-1:0];
		map_req.phys_low   = rd_data_s1.phys_low;
		map_req.block_log2 = rd_data_s1.block_log2;
		map_req.nodes_log2 = rd_data_s1.nodes_log2;
		map_req.start_node = rd_data_s1.start_node;
	end

	// region table: one write port on install, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[count_q[IDX_W-1:0]] <= new_entry;
		end
		if (issue) begin
			rd_data_s1 <= entries_q[idx_q[IDX_W-1:0]];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			// hold only reads issued during the scan
			rd_valid_s1 <= issue;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc) begin
						if (in_kind == KIND_INSTALL) begin
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					// first match wins; drop the read still in flight
					if (hit) begin
						state_q <= ST_MAP;
					end else if (!issue) begin
						state_q <= ST_RESP;
					end
				end
				ST_MAP: begin
					if (map_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			virt_q       <= s_axis_tdata[OFS_VIRT +: VA_W];
			res_data_q   <= '0;
			res_status_q <= full ? STATUS_FULL : STATUS_OK;
		end
		if ((state_q == ST_SCAN) && !hit && !issue) begin
			res_data_q   <= '0;
			res_status_q <= STATUS_MISS;
		end
		if ((state_q == ST_MAP) && map_done) begin
			res_data_q   <= map_addr;
			res_status_q <= STATUS_OK;
		end
		if (out_load) begin
			m_data_q <= res_data_q;
			m_user_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// ---------------------------------------------------------------- mapping
	irat_map #(
		.NODE_LOG2(NODE_LOG2)
	) u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (hit),
		.req          (map_req),
		.window_base  (window_q),
		.mem_per_node (mpn_q),
		.done         (map_done),
		.phys_addr    (map_addr)
	);

endmodule

`default_nettype wire

// ===== src/irat_chk.sv =====
// Port-level checks for the interleaved region address translator, bound to the top level.
// Depends on irat_pkg.
`default_nettype none

module irat_chk
	import irat_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [VA_W-1:0]   m_axis_tdata,
	input wire logic [STAT_W-1:0] m_axis_tuser
);

	// a result that is not ok carries a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> m_axis_tdata == '0)
		else $error("non-ok result with nonzero address");

	// status is one of the three defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_MISS)
		|| (m_axis_tuser == STATUS_FULL))
		else $error("undefined status code");

	// one item at a time: input is closed right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken back to back");

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

endmodule

bind interleaved_region_address_translate irat_chk u_irat_chk (.*);

`default_nettype wire

// ===== test/region_translate_checker.sv =====
// Scoreboard for the interleaved region address translator: watches the input, result and
// APB channels, keeps a shadow region table and registers, and counts mismatches.
// Depends on irat_pkg for field layout, status codes and register select.
module region_translate_checker
	import irat_pkg::*;
#(
	parameter int TABLE_SIZE = 16,
	parameter int NODE_LIMIT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	// tdata: virt_addr, region_bytes, region_phys, block_log2, nodes_log2, first_node, pad
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	// tuser: kind
	input  wire logic [0:0]            s_axis_tuser,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tdata: phys_addr
	input  wire logic [VA_W-1:0]       m_axis_tdata,
	// tuser: status
	input  wire logic [STAT_W-1:0]     m_axis_tuser,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [63:0]           pwdata,
	input  wire logic [63:0]           prdata,
	input  wire logic                  pready,
	output int unsigned                mismatches,
	output int unsigned                pending,
	output int unsigned                ok_cnt,
	output int unsigned                miss_cnt,
	output int unsigned                full_cnt
);

	typedef struct packed {
		logic [VA_W-1:0]   phys;
		logic [STAT_W-1:0] status;
	} reply_t;

	entry_t            regions [TABLE_SIZE];
	int unsigned       region_cnt;
	logic [63:0]       window_base;
	logic [63:0]       mem_per_node;
	reply_t            owed_replies [$];
	reply_t            want;

	initial begin
		mismatches = 0;
		ok_cnt     = 0;
		miss_cnt   = 0;
		full_cnt   = 0;
	end

	function automatic logic [63:0] ones(input int n);
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic logic [63:0] map_address(input entry_t e, input logic [63:0] va);
		logic [63:0] off, blk, node, in_node, boff;
		int          width;
		if (e.nodes_log2 == 0)
			return va;
		off   = va - e.va_base;
		width = PHYS_W + int'(e.nodes_log2) - int'(e.block_log2);
		blk   = '0;
		if (width > 0)
			blk = (off >> e.block_log2) & ones(width);
		node    = blk & ones(int'(e.nodes_log2));
		in_node = blk >> e.nodes_log2;
		boff    = off & ones(int'(e.block_log2));
		return window_base + mem_per_node * (node + 64'(e.start_node))
			+ (in_node << e.block_log2) + boff + 64'(e.phys_low);
	endfunction

	// Install into the shadow table or scan it; returns the reply the block owes.
	function automatic reply_t apply_item(input logic kind, input logic [IN_TDATA_W-1:0] w);
		reply_t      r;
		entry_t      e;
		logic [63:0] va;
		r.phys   = '0;
		r.status = STATUS_OK;
		va       = w[OFS_VIRT +: VA_W];
		if (kind == KIND_INSTALL) begin
			if (region_cnt >= TABLE_SIZE) begin
				r.status = STATUS_FULL;
				return r;
			end
			e.va_base    = va;
			e.length     = w[OFS_BYTES +: LEN_W];
			e.phys_low   = w[OFS_PHYS +: PHYS_W];
			e.block_log2 = w[OFS_BLK +: BLK_W];
			e.nodes_log2 = w[OFS_NODES +: NODES_W];
			e.start_node = w[OFS_FIRST +: START_W];
			// clamp the node count to what the block supports
			while (e.nodes_log2 > 0 && (64'd1 << e.nodes_log2) > NODE_LIMIT)
				e.nodes_log2--;
			regions[region_cnt] = e;
			region_cnt++;
			return r;
		end
		for (int i = 0; i < region_cnt; i++) begin
			if (va >= regions[i].va_base &&
			    va - regions[i].va_base < 64'(regions[i].length)) begin
				r.phys = map_address(regions[i], va);
				return r;
			end
		end
		r.status = STATUS_MISS;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] exp_val);
		mismatches++;
		$display("[%0t] %s: got %h, want %h", $time, what, got, exp_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_cnt   = 0;
			window_base  = '0;
			mem_per_node = '0;
			owed_replies.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_replies.size() == 0) begin
					report_mismatch("result with nothing expected", m_axis_tdata, '0);
				end else begin
					want = owed_replies.pop_front();
					if (m_axis_tdata !== want.phys)
						report_mismatch("phys_addr", m_axis_tdata, want.phys);
					if (m_axis_tuser !== want.status)
						report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
					case (want.status)
						STATUS_OK:   ok_cnt++;
						STATUS_MISS: miss_cnt++;
						default:     full_cnt++;
					endcase
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				owed_replies = {owed_replies, apply_item(s_axis_tuser[0], s_axis_tdata)};
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[CFG_SEL_BIT] == CFG_SEL_MPN)
						mem_per_node = 64'(pwdata[MPN_W-1:0]);
					else
						window_base = pwdata;
				end else if (paddr[CFG_SEL_BIT] == CFG_SEL_MPN) begin
					if (prdata !== mem_per_node)
						report_mismatch("mem_per_node readback", prdata, mem_per_node);
				end else if (prdata !== window_base) begin
					report_mismatch("window_base readback", prdata, window_base);
				end
			end
			pending <= owed_replies.size();
		end
	end

endmodule

// ===== test/tb_interleaved_region_address_translate.sv =====
// Stimulus and verdict for the interleaved region address translator.
// Drives install and translate items under several register settings; result checking
// lives in region_translate_checker and irat_chk. Depends on irat_pkg, the block and the checker.
module tb_interleaved_region_address_translate;
	import irat_pkg::*;

	localparam int TABLE_SIZE   = 16;
	localparam int CYCLE_LIMIT  = 400000;
	// wait after the last owed result so the tail of a full-table translate has room
	localparam int SETTLE       = 40;
	localparam int RANDOM_FIRST = 130;
	localparam int RANDOM_PHASE = 175;
	localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_BASE =
		CFG_ADDR_W'(CFG_SEL_WINDOW) << CFG_SEL_BIT;
	localparam logic [CFG_ADDR_W-1:0] ADDR_MEM_PER_NODE =
		CFG_ADDR_W'(CFG_SEL_MPN) << CFG_SEL_BIT;
	localparam logic [63:0] MPN_MAX = 64'd1 << 37;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tdata: virt_addr, region_bytes, region_phys, block_log2, nodes_log2, first_node, pad
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	// tuser: kind
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// tdata: phys_addr
	logic [VA_W-1:0]       m_axis_tdata;
	// tuser: status
	logic [STAT_W-1:0]     m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [63:0]           pwdata = '0;
	logic [63:0]           prdata;
	logic                  pready;

	int unsigned mismatches, pending, ok_cnt, miss_cnt, full_cnt;
	int unsigned items_sent = 0;
	int unsigned installs_sent = 0;
	int unsigned cycles = 0;
	// no idling on either side while set
	logic        calm = 1'b0;

	// what the stimulus knows of the table, used only to aim addresses at regions
	logic [63:0] known_base [TABLE_SIZE];
	logic [40:0] known_len  [TABLE_SIZE];
	int          known_cnt = 0;

	always #5 clk = ~clk;

	interleaved_region_address_translate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	region_translate_checker #(
		.TABLE_SIZE (TABLE_SIZE),
		.NODE_LIMIT (1024)
	) u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.pending       (pending),
		.ok_cnt        (ok_cnt),
		.miss_cnt      (miss_cnt),
		.full_cnt      (full_cnt)
	);

	// Receiver: drop tready about a third of the time unless calm.
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 34);
	end

	// Watchdog: end the run as failed if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, pending);
			$display("interleaved_region_address_translate regression: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Offer one item and hold it until the block takes it. A random gap lowers tvalid
	// first; back-to-back items keep tvalid high with a single assignment.
	task automatic offer(input logic kind, input logic [63:0] va, input logic [40:0] bytes,
		input logic [36:0] phys, input logic [5:0] blk, input logic [3:0] nodes,
		input logic [9:0] first);
		logic [IN_TDATA_W-1:0] word;
		int                    gap;
		word = '0;
		word[OFS_VIRT +: VA_W]     = va;
		word[OFS_BYTES +: LEN_W]   = bytes;
		word[OFS_PHYS +: PHYS_W]   = phys;
		word[OFS_BLK +: BLK_W]     = blk;
		word[OFS_NODES +: NODES_W] = nodes;
		word[OFS_FIRST +: START_W] = first;
		gap = (!calm && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic install(input logic [63:0] base, input logic [40:0] bytes,
		input logic [36:0] phys, input logic [5:0] blk, input logic [3:0] nodes,
		input logic [9:0] first);
		if (known_cnt < TABLE_SIZE) begin
			known_base[known_cnt] = base;
			known_len[known_cnt]  = bytes;
			known_cnt++;
		end
		installs_sent++;
		offer(KIND_INSTALL, base, bytes, phys, blk, nodes, first);
	endtask

	// Translate with noise in the fields the block ignores for this kind.
	task automatic translate(input logic [63:0] va);
		offer(KIND_TRANSLATE, va, 41'(rand64()), 37'(rand64()), 6'($urandom),
			4'($urandom), 10'($urandom));
	endtask

	// Mostly land inside or on the edges of a known region; some strays miss.
	function automatic logic [63:0] aim_address();
		int          k, sel;
		logic [63:0] span, off;
		sel = $urandom_range(99);
		if (known_cnt == 0 || sel >= 85)
			return rand64();
		k    = $urandom_range(known_cnt - 1);
		span = 64'(known_len[k]);
		if (sel >= 75)
			return known_base[k] - 64'd1;
		case ($urandom_range(7))
			0:       off = '0;
			1:       off = span - 64'd1;
			2:       off = span;
			default: off = (span == 0) ? '0 : rand64() % span;
		endcase
		return known_base[k] + off;
	endfunction

	task automatic random_install();
		logic [40:0] bytes;
		logic [5:0]  blk;
		case ($urandom_range(9))
			0, 1, 2: bytes = 41'($urandom_range(1, 4096));
			3:       bytes = '0;
			4:       bytes = '1;
			5:       bytes = 41'd1 << 40;
			default: bytes = 41'(rand64());
		endcase
		blk = ($urandom_range(9) < 7) ? 6'($urandom_range(7, 36)) : 6'($urandom_range(0, 63));
		install(rand64(), bytes, 37'(rand64()), blk, 4'($urandom_range(0, 15)),
			10'($urandom));
	endtask

	task automatic random_items(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 12)
				random_install();
			else
				translate(aim_address());
		end
	endtask

	// One APB transfer: setup, access, then park with psel low so psel never drops and
	// rises within the same step.
	task automatic apb_transfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
		input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both registers and read them back; the checker compares the read data.
	task automatic set_registers(input logic [63:0] wb, input logic [63:0] mpn);
		apb_transfer(1'b1, ADDR_WINDOW_BASE, wb);
		apb_transfer(1'b1, ADDR_MEM_PER_NODE, mpn);
		apb_transfer(1'b0, ADDR_WINDOW_BASE, '0);
		apb_transfer(1'b0, ADDR_MEM_PER_NODE, '0);
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 0: moderate window, 1 GiB per node, directed items first.
		set_registers(64'h0000_2000_0000_0000, 64'd1 << 30);

		// zero-length region: never matches, even at its base
		install(64'h0000_0000_0001_0000, '0, 37'h1_2345_6789, 6'd7, 4'd3, 10'd0);
		// single-node region on the same base: address passes through
		install(64'h0000_0000_0001_0000, 41'h1_0000, '1, 6'd36, 4'd0, '1);
		// widest length, node count above the limit
		install(64'h4000_0000_0000_0000, '1, '0, 6'd7, 4'd15, '1);
		// hidden behind the region above: first match wins
		install(64'h4000_0000_0000_0100, 41'h1000, 37'h55, 6'd12, 4'd2, 10'd7);
		// top of the address space: the range test must not wrap; block number empty
		install(64'hFFFF_FFFF_FFFF_0000, '1, 37'h10_0000_0000, 6'd63, 4'd1, 10'd3);
		// block field width exactly zero
		install(64'h8000_0000_0000_0000, 41'd1 << 40, 37'h0_0000_1000, 6'd39, 4'd2,
			10'd512);
		// block size one byte, most nodes
		install(64'h9000_0000_0000_0000, 41'h10_0000, 37'h0A_BCDE_F012, 6'd0, 4'd10,
			10'd5);
		install(64'hA000_0000_0000_0000, 41'd1 << 36, 37'h1F_0000_0001, 6'd36, 4'd1,
			10'd1);

		translate('0);
		translate(64'h0000_0000_0001_0000);
		translate(64'h0000_0000_0001_FFFF);
		translate(64'h0000_0000_0002_0000);
		translate(64'h4000_0000_0000_0000);
		translate(64'h4000_0000_0000_0180);
		translate(64'h4000_01FF_FFFF_FFFE);
		translate(64'h4000_01FF_FFFF_FFFF);
		translate('1);
		translate(64'h8000_00AB_CDEF_1234);
		translate(64'h9000_0000_000F_FFFF);
		translate(64'hA000_000F_FFFF_FFFF);
		random_items(RANDOM_FIRST);
		drain();

		// Phase 1: window at the very top, per-node size 2^37; sums wrap.
		set_registers('1, MPN_MAX);
		random_items(RANDOM_PHASE);
		drain();

		// Phase 2: both registers zero, and no idling on either side.
		calm <= 1'b1;
		set_registers('0, '0);
		random_items(RANDOM_PHASE);
		drain();
		calm <= 1'b0;

		// Phases 3 and 4: random settings.
		set_registers(rand64(), rand64() % (MPN_MAX + 64'd1));
		random_items(RANDOM_PHASE);
		drain();
		set_registers(rand64(), MPN_MAX);
		random_items(RANDOM_PHASE);
		drain();

		$display("sent %0d items (%0d installs, %0d translates) over five register settings",
			items_sent, installs_sent, items_sent - installs_sent);
		$display("results: %0d ok, %0d not found, %0d table full; %0d mismatches",
			ok_cnt, miss_cnt, full_cnt, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("interleaved_region_address_translate regression: pass");
		else
			$display("interleaved_region_address_translate regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/irat_pkg.sv
src/irat_map.sv
src/interleaved_region_address_translate.sv
src/irat_chk.sv
test/region_translate_checker.sv
test/tb_interleaved_region_address_translate.sv
